// ===== hw/rtl/csm_pkg.sv =====
package csm_pkg;

	localparam int MAX_SIZE    = 64;
	localparam int MAX_ENTRIES = 512;
	localparam int RESULT_LIMIT = 64;

	localparam int IDX_W  = $clog2(MAX_SIZE);
	localparam int N_W    = $clog2(MAX_SIZE + 1);
	localparam int ENT_AW = $clog2(MAX_ENTRIES);
	localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
	localparam int VAL_W  = 32;
	localparam int PROD_W = 2 * VAL_W;
	localparam int FRAC_W = 16;
	localparam int RND_W  = PROD_W - FRAC_W;
	localparam int ACC_W  = RND_W + ENT_AW + 1;
	localparam int Q_W    = VAL_W + FRAC_W;

	typedef enum logic [1:0] {
		OP_ENTRY  = 2'd0,
		OP_RHS    = 2'd1,
		OP_RESULT = 2'd2,
		OP_RUN    = 2'd3
	} op_t;

	localparam logic [2:0] MODE_AB     = 3'd0;
	localparam logic [2:0] MODE_ATB    = 3'd1;
	localparam logic [2:0] MODE_JACOBI = 3'd2;
	localparam logic [2:0] MODE_FWD    = 3'd3;
	localparam logic [2:0] MODE_BWD    = 3'd4;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NODIAG = 2'd1;
	localparam logic [1:0] ST_SAT    = 2'd2;

	localparam logic [1:0] CFG_MODE  = 2'd0;
	localparam logic [1:0] CFG_SCALE = 2'd1;
	localparam logic [1:0] CFG_SIZE  = 2'd2;

	typedef struct packed {
		logic                    vld;
		logic [IDX_W-1:0]        row;
		logic [IDX_W-1:0]        col;
		logic signed [VAL_W-1:0] value;
	} ld_req_t;

	typedef struct packed {
		logic              rs_rd;
		logic [N_W-1:0]    rs_addr;
		logic              ent_rd;
		logic [ENT_AW-1:0] ent_addr;
		logic              dg_rd;
		logic [IDX_W-1:0]  dg_addr;
	} rd_req_t;

	typedef struct packed {
		logic [CNT_W-1:0]        rs_data;
		logic [IDX_W-1:0]        ent_col;
		logic signed [VAL_W-1:0] ent_val;
		logic                    dg_found;
		logic [ENT_AW-1:0]       dg_pos;
	} rd_rsp_t;

	typedef struct packed {
		logic                    start;
		logic signed [VAL_W-1:0] num;
		logic signed [VAL_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                    done;
		logic                    sat;
		logic signed [VAL_W-1:0] q;
	} div_rsp_t;

	typedef struct packed {
		logic                    flag;
		logic signed [VAL_W-1:0] v;
	} sat_t;

	function automatic sat_t sat32(input logic signed [ACC_W-1:0] v);
		sat_t r;
		if ((v[ACC_W-1:VAL_W-1] == '0) || (v[ACC_W-1:VAL_W-1] == '1)) begin
			r.flag = 1'b0;
			r.v    = v[VAL_W-1:0];
		end else begin
			r.flag = 1'b1;
			r.v    = v[ACC_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
		end
		return r;
	endfunction

	// round a Q32.32 product to Q32.16: add half an LSB, floor
	function automatic logic signed [RND_W-1:0] qround(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] t;
		t = p + PROD_W'(1 << (FRAC_W - 1));
		return t[PROD_W-1:FRAC_W];
	endfunction

	function automatic logic signed [ACC_W-1:0] sext_val(input logic signed [VAL_W-1:0] x);
		return {{(ACC_W-VAL_W){x[VAL_W-1]}}, x};
	endfunction

	function automatic logic signed [ACC_W-1:0] sext_rnd(input logic signed [RND_W-1:0] x);
		return {{(ACC_W-RND_W){x[RND_W-1]}}, x};
	endfunction

endpackage

// ===== hw/rtl/csm_div.sv =====
module csm_div (
	input  logic              clk,
	input  logic              arst_n,
	input  csm_pkg::div_req_t req,
	output csm_pkg::div_rsp_t rsp
);

	logic                           busy_q;
	logic                           done_q;
	logic                           neg_q;
	logic [5:0]                     cnt_q;
	logic [csm_pkg::VAL_W-1:0]      den_q;
	logic [csm_pkg::VAL_W-1:0]      rem_q;
	logic [csm_pkg::Q_W-1:0]        quo_q;
	logic [csm_pkg::VAL_W:0]        rem_sh;
	logic                           ge;
	logic [csm_pkg::VAL_W-1:0]      abs_num;
	logic [csm_pkg::VAL_W-1:0]      abs_den;
	logic [csm_pkg::VAL_W-1:0]      neg_low;

	assign abs_num = req.num[csm_pkg::VAL_W-1] ? (~req.num + 1'b1) : req.num;
	assign abs_den = req.den[csm_pkg::VAL_W-1] ? (~req.den + 1'b1) : req.den;
	assign rem_sh  = {rem_q, quo_q[csm_pkg::Q_W-1]};
	assign ge      = rem_sh >= {1'b0, den_q};

	// one quotient bit per cycle on magnitudes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			neg_q  <= 1'b0;
			cnt_q  <= '0;
			den_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				neg_q  <= req.num[csm_pkg::VAL_W-1] ^ req.den[csm_pkg::VAL_W-1];
				cnt_q  <= '0;
				den_q  <= abs_den;
				rem_q  <= '0;
				quo_q  <= {abs_num, {csm_pkg::FRAC_W{1'b0}}};
			end else if (busy_q) begin
				rem_q <= ge ? csm_pkg::VAL_W'(rem_sh - {1'b0, den_q})
				            : rem_sh[csm_pkg::VAL_W-1:0];
				quo_q <= {quo_q[csm_pkg::Q_W-2:0], ge};
				if (cnt_q == 6'(csm_pkg::Q_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	assign neg_low = ~quo_q[csm_pkg::VAL_W-1:0] + 1'b1;

	always_comb begin
		rsp.done = done_q;
		if (!neg_q) begin
			rsp.sat = quo_q[csm_pkg::Q_W-1:csm_pkg::VAL_W-1] != '0;
			rsp.q   = rsp.sat ? {1'b0, {(csm_pkg::VAL_W-1){1'b1}}} : quo_q[csm_pkg::VAL_W-1:0];
		end else begin
			rsp.sat = (quo_q[csm_pkg::Q_W-1:csm_pkg::VAL_W] != '0) ||
			          (quo_q[csm_pkg::VAL_W-1] && (quo_q[csm_pkg::VAL_W-2:0] != '0));
			rsp.q   = rsp.sat ? {1'b1, {(csm_pkg::VAL_W-1){1'b0}}} : neg_low;
		end
	end

endmodule

// ===== hw/rtl/csm_mat.sv =====
module csm_mat (
	input  logic             clk,
	input  logic             arst_n,
	input  csm_pkg::ld_req_t ld,
	output logic             busy,
	input  csm_pkg::rd_req_t rq,
	output csm_pkg::rd_rsp_t rs
);

	logic [csm_pkg::IDX_W-1:0]        col_mem [csm_pkg::MAX_ENTRIES];
	logic signed [csm_pkg::VAL_W-1:0] val_mem [csm_pkg::MAX_ENTRIES];
	logic [csm_pkg::CNT_W-1:0]        rs_mem  [csm_pkg::MAX_SIZE];
	logic [csm_pkg::ENT_AW-1:0]       dg_mem  [csm_pkg::MAX_SIZE];

	logic [csm_pkg::CNT_W-1:0]  count_q;
	logic [csm_pkg::N_W-1:0]    filled_q;
	logic [csm_pkg::IDX_W-1:0]  last_row_q;
	logic [csm_pkg::IDX_W-1:0]  last_col_q;
	logic [csm_pkg::MAX_SIZE-1:0] found_q;
	logic                       busy_q;
	logic [csm_pkg::IDX_W-1:0]  fill_k_q;
	logic [csm_pkg::IDX_W-1:0]  fill_end_q;
	logic [csm_pkg::CNT_W-1:0]  fill_val_q;

	logic [csm_pkg::CNT_W-1:0]        rs_mem_q;
	logic                             rs_sel_q;
	logic [csm_pkg::CNT_W-1:0]        rs_cnt_q;
	logic [csm_pkg::IDX_W-1:0]        ent_col_q;
	logic signed [csm_pkg::VAL_W-1:0] ent_val_q;
	logic [csm_pkg::ENT_AW-1:0]       dg_pos_q;
	logic                             dg_found_q;

	logic                       ooo;
	logic [csm_pkg::CNT_W-1:0]  base_cnt;
	logic [csm_pkg::N_W-1:0]    base_fill;
	logic                       take;
	logic                       fill_need;
	logic                       diag_new;

	// an entry behind the last one in row-major order restarts the matrix
	assign ooo = (count_q != '0) &&
	             ((ld.row < last_row_q) || ((ld.row == last_row_q) && (ld.col < last_col_q)));
	assign base_cnt  = ooo ? '0 : count_q;
	assign base_fill = ooo ? '0 : filled_q;
	assign take      = ld.vld && (base_cnt != csm_pkg::CNT_W'(csm_pkg::MAX_ENTRIES));
	assign fill_need = base_fill <= {1'b0, ld.row};
	assign diag_new  = take && (ld.col == ld.row) && (ooo || !found_q[ld.row]);
	assign busy      = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			filled_q   <= '0;
			last_row_q <= '0;
			last_col_q <= '0;
			found_q    <= '0;
			busy_q     <= 1'b0;
			fill_k_q   <= '0;
			fill_end_q <= '0;
			fill_val_q <= '0;
		end else begin
			if (busy_q) begin
				if (fill_k_q == fill_end_q) begin
					busy_q <= 1'b0;
				end else begin
					fill_k_q <= fill_k_q + 1'b1;
				end
			end
			if (ld.vld) begin
				if (ooo) begin
					count_q  <= '0;
					filled_q <= '0;
					found_q  <= '0;
				end
				if (take) begin
					count_q    <= base_cnt + 1'b1;
					last_row_q <= ld.row;
					last_col_q <= ld.col;
					if (fill_need) begin
						busy_q     <= 1'b1;
						fill_k_q   <= base_fill[csm_pkg::IDX_W-1:0];
						fill_end_q <= ld.row;
						fill_val_q <= base_cnt;
						filled_q   <= csm_pkg::N_W'(ld.row) + 1'b1;
					end
					if (diag_new) begin
						found_q[ld.row] <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			col_mem[base_cnt[csm_pkg::ENT_AW-1:0]] <= ld.col;
			val_mem[base_cnt[csm_pkg::ENT_AW-1:0]] <= ld.value;
		end
		if (rq.ent_rd) begin
			ent_col_q <= col_mem[rq.ent_addr];
			ent_val_q <= val_mem[rq.ent_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (diag_new) begin
			dg_mem[ld.row] <= base_cnt[csm_pkg::ENT_AW-1:0];
		end
		if (rq.dg_rd) begin
			dg_pos_q   <= dg_mem[rq.dg_addr];
			dg_found_q <= found_q[rq.dg_addr];
		end
	end

	// rows at or past the fill mark start at the current entry count
	always_ff @(posedge clk) begin
		if (busy_q) begin
			rs_mem[fill_k_q] <= fill_val_q;
		end
		if (rq.rs_rd) begin
			rs_mem_q <= rs_mem[rq.rs_addr[csm_pkg::IDX_W-1:0]];
			rs_sel_q <= rq.rs_addr < filled_q;
			rs_cnt_q <= count_q;
		end
	end

	always_comb begin
		rs.rs_data  = rs_sel_q ? rs_mem_q : rs_cnt_q;
		rs.ent_col  = ent_col_q;
		rs.ent_val  = ent_val_q;
		rs.dg_found = dg_found_q;
		rs.dg_pos   = dg_pos_q;
	end

endmodule

// ===== hw/rtl/csr_sparse_matvec_smoother.sv =====
// Sparse matrix engine in compressed-row form over signed Q16.16 values. Load matrix
// entries (op 0) in row-major order; an entry behind the previous one starts a new
// matrix. Load right-hand (op 1) and result (op 2) elements by index. A run (op 3)
// applies the configured mode to the first size_used rows and columns, then streams
// one result transfer per element, index 0 first, with last on the final one. An entry
// whose row is at or past the fill mark holds off input while the row-start table
// fills. A run is driven by one sequencer over the entry memory: the product modes
// copy the result elements into the accumulators, visit the entries of each row and
// finish the accumulators; the solve modes visit each row, its off-diagonal entries
// in the triangular modes and a shift-subtract divide by the diagonal; then each
// element is streamed and held until out_ready takes it. Input is not taken from the
// run item until its last element has transferred.
module csr_sparse_matvec_smoother (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [5:0]  row,
	input  logic [5:0]  col,
	input  logic signed [31:0] value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  index,
	output logic signed [31:0] result,
	output logic [1:0]  status,
	output logic        last
);

	typedef enum logic [4:0] {
		S_IDLE, S_INIT_RD, S_INIT_WR, S_ROW_A, S_ROW_B, S_ROW_C,
		S_E_RD, S_E_COL, S_E_MUL1, S_E_SAT, S_E_MUL2, S_E_ADD,
		S_FIN_RD, S_FIN_WR, S_W_RD, S_W_COL, S_W_MUL, S_W_SUB,
		S_SV_A, S_SV_B, S_SV_C, S_SV_DIV, S_O_RD, S_O_LD, S_O_WAIT
	} state_t;

	state_t state_q;

	// configuration
	logic [2:0]                       mode_q;
	logic signed [csm_pkg::VAL_W-1:0] scale_q;
	logic [csm_pkg::N_W-1:0]          size_q;

	// sequencer datapath
	logic [csm_pkg::N_W-1:0]           n_q;
	logic [csm_pkg::N_W-1:0]           i_q;
	logic [csm_pkg::CNT_W-1:0]         p_q;
	logic [csm_pkg::CNT_W-1:0]         pend_q;
	logic [csm_pkg::CNT_W-1:0]         pstart_q;
	logic [csm_pkg::IDX_W-1:0]         dst_q;
	logic signed [csm_pkg::VAL_W-1:0]  val_q;
	logic signed [csm_pkg::VAL_W-1:0]  pr_q;
	logic                              sata_q;
	logic signed [csm_pkg::PROD_W-1:0] prod_q;
	logic signed [csm_pkg::ACC_W-1:0]  sum_q;
	logic                              ssat_q;

	// vector memories
	logic signed [csm_pkg::VAL_W-1:0] rhs_mem  [csm_pkg::MAX_SIZE];
	logic signed [csm_pkg::VAL_W-1:0] res_mem  [csm_pkg::MAX_SIZE];
	logic [csm_pkg::ACC_W:0]          acc_mem  [csm_pkg::MAX_SIZE];
	logic [1:0]                       stat_mem [csm_pkg::MAX_SIZE];
	logic [csm_pkg::MAX_SIZE-1:0]     res_vld_q;

	logic signed [csm_pkg::VAL_W-1:0] rhs_q;
	logic signed [csm_pkg::VAL_W-1:0] res_q;
	logic                             res_vld_r;
	logic [csm_pkg::ACC_W:0]          acc_q;
	logic [1:0]                       stat_q;

	// memory port controls
	logic                             rhs_rd, rhs_we;
	logic [csm_pkg::IDX_W-1:0]        rhs_raddr;
	logic                             res_rd, res_we;
	logic [csm_pkg::IDX_W-1:0]        res_raddr, res_waddr;
	logic signed [csm_pkg::VAL_W-1:0] res_wdata;
	logic                             stat_rd, stat_we;
	logic [1:0]                       stat_wdata;
	logic                             acc_rd, acc_we;
	logic [csm_pkg::IDX_W-1:0]        acc_raddr, acc_waddr;
	logic [csm_pkg::ACC_W:0]          acc_wdata;

	csm_pkg::ld_req_t  mat_ld;
	csm_pkg::rd_req_t  mat_rq;
	csm_pkg::rd_rsp_t  mat_rs;
	csm_pkg::div_req_t div_rq;
	csm_pkg::div_rsp_t div_rs;
	logic              mat_busy;

	logic                             accept;
	logic                             mode_prod;
	logic                             mode_bwd;
	logic                             elem_last;
	logic                             col_in;
	logic [csm_pkg::N_W-1:0]          n_clamp;
	logic signed [csm_pkg::VAL_W-1:0] res_value;
	csm_pkg::sat_t                    s_fin;
	csm_pkg::sat_t                    s_sum;
	csm_pkg::sat_t                    s_pr;

	csm_mat u_mat (
		.clk    (clk),
		.arst_n (arst_n),
		.ld     (mat_ld),
		.busy   (mat_busy),
		.rq     (mat_rq),
		.rs     (mat_rs)
	);

	csm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_rq),
		.rsp    (div_rs)
	);

	assign in_ready  = (state_q == S_IDLE) && !mat_busy;
	assign accept    = in_valid && in_ready;
	assign mode_prod = (mode_q == csm_pkg::MODE_AB) || (mode_q == csm_pkg::MODE_ATB);
	assign mode_bwd  = mode_q == csm_pkg::MODE_BWD;
	assign elem_last = mode_bwd ? (i_q == '0) : (i_q == n_q - 1'b1);
	assign col_in    = {1'b0, mat_rs.ent_col} < n_q;
	assign res_value = res_vld_r ? res_q : '0;
	assign s_fin     = csm_pkg::sat32(acc_q[csm_pkg::ACC_W-1:0]);
	assign s_sum     = csm_pkg::sat32(sum_q);
	assign s_pr      = csm_pkg::sat32(csm_pkg::sext_rnd(csm_pkg::qround(prod_q)));

	// clamp the dimension to 1..MAX_SIZE and to the result limit
	always_comb begin
		n_clamp = size_q;
		if (size_q == '0) begin
			n_clamp = csm_pkg::N_W'(1);
		end else if (size_q > csm_pkg::N_W'(csm_pkg::MAX_SIZE)) begin
			n_clamp = csm_pkg::N_W'(csm_pkg::MAX_SIZE);
		end
		if (n_clamp > csm_pkg::N_W'(csm_pkg::RESULT_LIMIT)) begin
			n_clamp = csm_pkg::N_W'(csm_pkg::RESULT_LIMIT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= csm_pkg::MODE_AB;
			scale_q <= 32'sh0001_0000;
			size_q  <= csm_pkg::N_W'(64);
		end else if (cfg_we) begin
			case (cfg_index)
				csm_pkg::CFG_MODE:  mode_q  <= cfg_data[2:0];
				csm_pkg::CFG_SCALE: scale_q <= cfg_data;
				csm_pkg::CFG_SIZE:  size_q  <= cfg_data[csm_pkg::N_W-1:0];
				default: ;
			endcase
		end
	end

	// memory port selection per sequencer step
	always_comb begin
		rhs_rd     = 1'b0;
		rhs_we     = 1'b0;
		rhs_raddr  = i_q[csm_pkg::IDX_W-1:0];
		res_rd     = 1'b0;
		res_we     = 1'b0;
		res_raddr  = i_q[csm_pkg::IDX_W-1:0];
		res_waddr  = i_q[csm_pkg::IDX_W-1:0];
		res_wdata  = '0;
		stat_rd    = 1'b0;
		stat_we    = 1'b0;
		stat_wdata = csm_pkg::ST_OK;
		acc_rd     = 1'b0;
		acc_we     = 1'b0;
		acc_raddr  = i_q[csm_pkg::IDX_W-1:0];
		acc_waddr  = i_q[csm_pkg::IDX_W-1:0];
		acc_wdata  = '0;
		mat_ld.vld   = 1'b0;
		mat_ld.row   = row;
		mat_ld.col   = col;
		mat_ld.value = value;
		mat_rq.rs_rd    = 1'b0;
		mat_rq.rs_addr  = i_q;
		mat_rq.ent_rd   = 1'b0;
		mat_rq.ent_addr = p_q[csm_pkg::ENT_AW-1:0];
		mat_rq.dg_rd    = 1'b0;
		mat_rq.dg_addr  = i_q[csm_pkg::IDX_W-1:0];
		div_rq.start = 1'b0;
		div_rq.num   = s_sum.v;
		div_rq.den   = mat_rs.ent_val;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (csm_pkg::op_t'(op))
						csm_pkg::OP_ENTRY: mat_ld.vld = 1'b1;
						csm_pkg::OP_RHS:   rhs_we = 1'b1;
						csm_pkg::OP_RESULT: begin
							res_we    = 1'b1;
							res_waddr = row;
							res_wdata = value;
						end
						default: ;
					endcase
				end
			end
			S_INIT_RD: res_rd = 1'b1;
			S_INIT_WR: begin
				acc_we    = 1'b1;
				acc_wdata = {1'b0, csm_pkg::sext_val(res_value)};
			end
			S_ROW_A: begin
				mat_rq.rs_rd = 1'b1;
				rhs_rd       = 1'b1;
			end
			S_ROW_B: begin
				mat_rq.rs_rd   = 1'b1;
				mat_rq.rs_addr = i_q + 1'b1;
			end
			S_E_RD: mat_rq.ent_rd = p_q < pend_q;
			S_E_COL: begin
				rhs_rd    = col_in;
				rhs_raddr = (mode_q == csm_pkg::MODE_AB) ? mat_rs.ent_col
				                                         : i_q[csm_pkg::IDX_W-1:0];
			end
			S_E_SAT: begin
				acc_rd    = 1'b1;
				acc_raddr = dst_q;
			end
			S_E_ADD: begin
				acc_we    = 1'b1;
				acc_waddr = dst_q;
				acc_wdata = {acc_q[csm_pkg::ACC_W] | sata_q,
				             acc_q[csm_pkg::ACC_W-1:0] +
				             csm_pkg::sext_rnd(csm_pkg::qround(prod_q))};
			end
			S_FIN_RD: acc_rd = 1'b1;
			S_FIN_WR: begin
				res_we     = 1'b1;
				res_wdata  = s_fin.v;
				stat_we    = 1'b1;
				stat_wdata = (acc_q[csm_pkg::ACC_W] | s_fin.flag) ? csm_pkg::ST_SAT
				                                                  : csm_pkg::ST_OK;
			end
			S_W_RD: begin
				if (mode_bwd) begin
					mat_rq.ent_rd   = p_q > pstart_q;
					mat_rq.ent_addr = csm_pkg::ENT_AW'(p_q - 1'b1);
				end else begin
					mat_rq.ent_rd   = p_q < pend_q;
				end
			end
			S_W_COL: begin
				res_raddr = mat_rs.ent_col;
				if (mode_bwd) begin
					res_rd = ({1'b0, mat_rs.ent_col} > i_q) && col_in;
				end else begin
					res_rd = {1'b0, mat_rs.ent_col} < i_q;
				end
			end
			S_SV_A: mat_rq.dg_rd = 1'b1;
			S_SV_B: begin
				if (mat_rs.dg_found) begin
					mat_rq.ent_rd   = 1'b1;
					mat_rq.ent_addr = mat_rs.dg_pos;
				end else begin
					res_we     = 1'b1;
					stat_we    = 1'b1;
					stat_wdata = csm_pkg::ST_NODIAG;
				end
			end
			S_SV_C: begin
				if (mat_rs.ent_val == '0) begin
					res_we     = 1'b1;
					stat_we    = 1'b1;
					stat_wdata = csm_pkg::ST_SAT;
				end else begin
					div_rq.start = 1'b1;
				end
			end
			S_SV_DIV: begin
				if (div_rs.done) begin
					res_we     = 1'b1;
					res_wdata  = div_rs.q;
					stat_we    = 1'b1;
					stat_wdata = (ssat_q | div_rs.sat) ? csm_pkg::ST_SAT : csm_pkg::ST_OK;
				end
			end
			S_O_RD: begin
				res_rd  = 1'b1;
				stat_rd = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (rhs_we) begin
			rhs_mem[row] <= value;
		end
		if (rhs_rd) begin
			rhs_q <= rhs_mem[rhs_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (res_we) begin
			res_mem[res_waddr] <= res_wdata;
		end
		if (res_rd) begin
			res_q     <= res_mem[res_raddr];
			res_vld_r <= res_vld_q[res_raddr];
		end
	end

	// result elements never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= '0;
		end else if (res_we) begin
			res_vld_q[res_waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_we) begin
			acc_mem[acc_waddr] <= acc_wdata;
		end
		if (acc_rd) begin
			acc_q <= acc_mem[acc_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (stat_we) begin
			stat_mem[i_q[csm_pkg::IDX_W-1:0]] <= stat_wdata;
		end
		if (stat_rd) begin
			stat_q <= stat_mem[i_q[csm_pkg::IDX_W-1:0]];
		end
	end

	// sequencer: state, datapath registers and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			n_q       <= '0;
			i_q       <= '0;
			p_q       <= '0;
			pend_q    <= '0;
			pstart_q  <= '0;
			dst_q     <= '0;
			val_q     <= '0;
			pr_q      <= '0;
			sata_q    <= 1'b0;
			prod_q    <= '0;
			sum_q     <= '0;
			ssat_q    <= 1'b0;
			out_valid <= 1'b0;
			index     <= '0;
			result    <= '0;
			status    <= csm_pkg::ST_OK;
			last      <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept && (csm_pkg::op_t'(op) == csm_pkg::OP_RUN)) begin
						n_q <= n_clamp;
						i_q <= mode_bwd ? n_clamp - 1'b1 : '0;
						if (mode_prod) begin
							state_q <= S_INIT_RD;
						end else if ((mode_q == csm_pkg::MODE_JACOBI) ||
						             (mode_q == csm_pkg::MODE_FWD) || mode_bwd) begin
							state_q <= S_ROW_A;
						end else begin
							state_q <= S_O_RD;
						end
					end
				end
				S_INIT_RD: state_q <= S_INIT_WR;
				S_INIT_WR: begin
					if (i_q == n_q - 1'b1) begin
						i_q     <= '0;
						state_q <= S_ROW_A;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_INIT_RD;
					end
				end
				S_ROW_A: state_q <= S_ROW_B;
				S_ROW_B: begin
					p_q      <= mat_rs.rs_data;
					pstart_q <= mat_rs.rs_data;
					sum_q    <= csm_pkg::sext_val(rhs_q);
					state_q  <= S_ROW_C;
				end
				S_ROW_C: begin
					pend_q <= mat_rs.rs_data;
					if (mode_bwd) begin
						p_q <= mat_rs.rs_data;
					end
					if (mode_prod) begin
						state_q <= S_E_RD;
					end else if (mode_q == csm_pkg::MODE_JACOBI) begin
						state_q <= S_SV_A;
					end else begin
						state_q <= S_W_RD;
					end
				end
				S_E_RD: begin
					if (p_q < pend_q) begin
						state_q <= S_E_COL;
					end else if (i_q == n_q - 1'b1) begin
						i_q     <= '0;
						state_q <= S_FIN_RD;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_ROW_A;
					end
				end
				S_E_COL: begin
					if (col_in) begin
						dst_q   <= (mode_q == csm_pkg::MODE_AB) ? i_q[csm_pkg::IDX_W-1:0]
						                                        : mat_rs.ent_col;
						val_q   <= mat_rs.ent_val;
						state_q <= S_E_MUL1;
					end else begin
						p_q     <= p_q + 1'b1;
						state_q <= S_E_RD;
					end
				end
				S_E_MUL1: begin
					prod_q  <= $signed(val_q) * $signed(rhs_q);
					state_q <= S_E_SAT;
				end
				S_E_SAT: begin
					pr_q    <= s_pr.v;
					sata_q  <= s_pr.flag;
					state_q <= S_E_MUL2;
				end
				S_E_MUL2: begin
					prod_q  <= $signed(pr_q) * $signed(scale_q);
					state_q <= S_E_ADD;
				end
				S_E_ADD: begin
					p_q     <= p_q + 1'b1;
					state_q <= S_E_RD;
				end
				S_FIN_RD: state_q <= S_FIN_WR;
				S_FIN_WR: begin
					if (i_q == n_q - 1'b1) begin
						i_q     <= '0;
						state_q <= S_O_RD;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_FIN_RD;
					end
				end
				S_W_RD: begin
					if (mat_rq.ent_rd) begin
						state_q <= S_W_COL;
					end else begin
						state_q <= S_SV_A;
					end
				end
				S_W_COL: begin
					if (res_rd) begin
						val_q   <= mat_rs.ent_val;
						state_q <= S_W_MUL;
					end else if (mode_bwd && ({1'b0, mat_rs.ent_col} > i_q)) begin
						// column beyond the dimension: skip it
						p_q     <= p_q - 1'b1;
						state_q <= S_W_RD;
					end else begin
						state_q <= S_SV_A;
					end
				end
				S_W_MUL: begin
					prod_q  <= $signed(val_q) * $signed(res_value);
					state_q <= S_W_SUB;
				end
				S_W_SUB: begin
					sum_q   <= sum_q - csm_pkg::sext_rnd(csm_pkg::qround(prod_q));
					p_q     <= mode_bwd ? p_q - 1'b1 : p_q + 1'b1;
					state_q <= S_W_RD;
				end
				S_SV_A: state_q <= S_SV_B;
				S_SV_B: begin
					if (mat_rs.dg_found) begin
						state_q <= S_SV_C;
					end else if (elem_last) begin
						i_q     <= '0;
						state_q <= S_O_RD;
					end else begin
						i_q     <= mode_bwd ? i_q - 1'b1 : i_q + 1'b1;
						state_q <= S_ROW_A;
					end
				end
				S_SV_C: begin
					ssat_q <= s_sum.flag;
					if (mat_rs.ent_val != '0) begin
						state_q <= S_SV_DIV;
					end else if (elem_last) begin
						i_q     <= '0;
						state_q <= S_O_RD;
					end else begin
						i_q     <= mode_bwd ? i_q - 1'b1 : i_q + 1'b1;
						state_q <= S_ROW_A;
					end
				end
				S_SV_DIV: begin
					if (div_rs.done) begin
						if (elem_last) begin
							i_q     <= '0;
							state_q <= S_O_RD;
						end else begin
							i_q     <= mode_bwd ? i_q - 1'b1 : i_q + 1'b1;
							state_q <= S_ROW_A;
						end
					end
				end
				S_O_RD: state_q <= S_O_LD;
				S_O_LD: begin
					out_valid <= 1'b1;
					index     <= i_q[csm_pkg::IDX_W-1:0];
					result    <= res_value;
					status    <= (mode_q > csm_pkg::MODE_BWD) ? csm_pkg::ST_OK : stat_q;
					last      <= i_q == n_q - 1'b1;
					state_q   <= S_O_WAIT;
				end
				S_O_WAIT: begin
					// hold the element until the transfer completes
					if (out_ready) begin
						out_valid <= 1'b0;
						if (last) begin
							state_q <= S_IDLE;
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= S_O_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
